// ===== design/led_strip_pixel_encoder_macros.svh =====
// Assertion macros for the pixel encoder; the controller (lsp_ctrl) uses them.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef LED_STRIP_PIXEL_ENCODER_MACROS_SVH
`define LED_STRIP_PIXEL_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define LSP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lsp check failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define LSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lsp check failed: next-cycle implication");

`else

`define LSP_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define LSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== design/lsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsp_pkg;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_FILL = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } lsp_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_FILL,
    ST_RD_Q,
    ST_RD_MEM,
    ST_RD_SEL
  } lsp_state_t;

  localparam logic CFG_DIVISOR = 1'b0;
  localparam logic CFG_ORDER   = 1'b1;

  localparam int BYTES_PER_LED = 9;
  localparam int IMG_W         = 72;
  localparam int DIV_STEPS     = 8;

  // floor(k / 9) == (k * 911) >> 13 for every 10-bit k
  localparam logic [19:0] RECIP_MUL   = 20'd911;
  localparam int          RECIP_SHIFT = 13;

  localparam logic [2:0] LINE_ZERO = 3'b100;
  localparam logic [2:0] LINE_ONE  = 3'b110;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rd_q;
    logic rd_mem;
    logic sel_byte;
    logic mem_we;
    logic use_sweep;
    logic wr_zero;
  } lsp_cmd_t;

  typedef struct packed {
    logic pos_ok;
    logic idx_ok;
    logic idx_zero;
  } lsp_status_t;

  function automatic logic [23:0] expand_channel(input logic [7:0] v);
    logic [23:0] code;
    code = '0;
    for (int i = 0; i < 8; i++) begin
      code[23 - 3*i -: 3] = v[7 - i] ? LINE_ONE : LINE_ZERO;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== design/lsp_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsp_divider import lsp_pkg::*; (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire logic            step,
  input  wire logic [2:0][7:0] num_in,
  input  wire logic [7:0]      divisor,
  output logic      [2:0][7:0] quo
);

  // three restoring lanes, one quotient bit per lane per step
  logic [2:0][7:0] num_r, num_nxt;
  logic [2:0][7:0] rem_r, rem_nxt;

  always_comb begin
    logic [8:0] shifted;
    num_nxt = num_r;
    rem_nxt = rem_r;
    for (int l = 0; l < 3; l++) begin
      shifted = {rem_r[l], num_r[l][7]};
      if (shifted >= {1'b0, divisor}) begin
        rem_nxt[l] = 8'(shifted - {1'b0, divisor});
        num_nxt[l] = {num_r[l][6:0], 1'b1};
      end else begin
        rem_nxt[l] = shifted[7:0];
        num_nxt[l] = {num_r[l][6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      num_r <= num_in;
      rem_r <= '0;
    end else if (step) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo = num_r;

endmodule

`default_nettype wire

// ===== design/lsp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsp_datapath import lsp_pkg::*; #(
  parameter int LED_COUNT = 64,
  parameter int AW        = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic [1:0]  in_operation,
  input  wire logic [5:0]  in_position,
  input  wire logic [23:0] in_color,
  input  wire logic [9:0]  in_byte_index,
  input  wire lsp_cmd_t    cmd,
  input  wire logic [AW-1:0] sweep_addr,
  output lsp_status_t      status,
  output logic [7:0]       out_data_byte,
  output logic             out_bad_index
);

  localparam int IDX_MAX = BYTES_PER_LED * LED_COUNT;

  logic [7:0]       divisor_r;
  logic             order_r;
  logic [AW-1:0]    pos_r;
  logic [9:0]       k_r;
  logic [6:0]       q_r;
  logic [3:0]       r_r;
  logic [IMG_W-1:0] rdata_r;
  logic [7:0]       data_r;
  logic             bad_r;

  logic [IMG_W-1:0] mem [LED_COUNT];

  logic [2:0][7:0]  num_in;
  logic [2:0][7:0]  quo;
  logic [IMG_W-1:0] image;
  logic [IMG_W-1:0] wr_data;
  logic [AW-1:0]    wr_addr;
  logic [19:0]      prod;
  logic [9:0]       nine_q;
  logic [7:0]       sel;
  logic             bad_now;
  lsp_op_t          op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= '0;
      order_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIVISOR: divisor_r <= cfg_wdata;
        CFG_ORDER:   order_r   <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  assign op = lsp_op_t'(in_operation);

  always_comb begin
    status.pos_ok   = 32'(in_position) < 32'(LED_COUNT);
    status.idx_ok   = 32'(in_byte_index) <= 32'(IDX_MAX);
    status.idx_zero = in_byte_index == 10'd0;
    bad_now = (op == OP_SET && !status.pos_ok) || (op == OP_READ && !status.idx_ok);
  end

  // lanes: 0 green, 1 red, 2 blue
  always_comb begin
    num_in[0] = order_r ? in_color[23:16] : in_color[15:8];
    num_in[1] = order_r ? in_color[15:8]  : in_color[23:16];
    num_in[2] = in_color[7:0];
  end

  lsp_divider u_div (
    .clk     (clk),
    .load    (cmd.load),
    .step    (cmd.div_step),
    .num_in  (num_in),
    .divisor (divisor_r),
    .quo     (quo)
  );

  always_comb begin
    if (divisor_r == 8'd0) begin
      image = {3{expand_channel(8'd0)}};
    end else begin
      image = {expand_channel(quo[0]), expand_channel(quo[1]), expand_channel(quo[2])};
    end
    wr_data = cmd.wr_zero ? '0 : image;
    wr_addr = cmd.use_sweep ? sweep_addr : pos_r;
  end

  always_comb begin
    prod   = 20'(k_r) * RECIP_MUL;
    nine_q = {q_r, 3'b000} + 10'(q_r);
    sel    = 8'd0;
    for (int i = 0; i < BYTES_PER_LED; i++) begin
      if (r_r == 4'(i)) begin
        sel = rdata_r[IMG_W - 1 - 8*i -: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r  <= AW'(in_position);
      k_r    <= in_byte_index - 10'd1;
      data_r <= 8'd0;
      bad_r  <= bad_now;
    end
    if (cmd.rd_q) begin
      q_r <= 7'(prod >> RECIP_SHIFT);
    end
    if (cmd.rd_mem) begin
      r_r     <= 4'(k_r - nine_q);
      rdata_r <= mem[AW'(q_r)];
    end
    if (cmd.sel_byte) begin
      data_r <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign out_data_byte = data_r;
  assign out_bad_index = bad_r;

endmodule

`default_nettype wire

// ===== design/lsp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "led_strip_pixel_encoder_macros.svh"

module lsp_ctrl import lsp_pkg::*; #(
  parameter int LED_COUNT = 64,
  parameter int AW        = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [1:0]  in_operation,
  input  wire lsp_status_t status,
  output logic             busy,
  output logic             out_valid,
  output lsp_cmd_t         cmd,
  output logic [AW-1:0]    sweep_addr
);

  localparam int CW = (AW > 3) ? AW : 3;

  lsp_state_t  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  lsp_op_t     op_r, op_nxt;
  logic        valid_r, valid_nxt;
  logic        accept;
  logic        quick;
  logic        div_last;
  lsp_op_t     op_in;

  assign op_in  = lsp_op_t'(in_operation);
  // busy is low only in idle, so take the word straight from the state register
  assign accept = start && (state_r == ST_IDLE);

  assign div_last = (state_r == ST_DIV) && (cnt_r == CW'(DIV_STEPS - 1));

  // words that finish at once: no-op code, flagged index, pre-byte
  assign quick = (op_in == OP_NONE) ||
                 (op_in == OP_SET && !status.pos_ok) ||
                 (op_in == OP_READ && (!status.idx_ok || status.idx_zero));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      op_r    <= OP_NONE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.mem_we    = 1'b1;
        cmd.use_sweep = 1'b1;
        cmd.wr_zero   = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(LED_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          cmd.load = 1'b1;
          op_nxt   = op_in;
          cnt_nxt  = '0;
          if (quick) begin
            valid_nxt = 1'b1;
          end else if (op_in == OP_READ) begin
            state_nxt = ST_RD_Q;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (div_last) begin
          cnt_nxt   = '0;
          state_nxt = (op_r == OP_FILL) ? ST_FILL : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.mem_we = 1'b1;
        valid_nxt  = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_FILL: begin
        cmd.mem_we    = 1'b1;
        cmd.use_sweep = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CW'(LED_COUNT - 1)) begin
          cnt_nxt   = '0;
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_Q: begin
        cmd.rd_q  = 1'b1;
        state_nxt = ST_RD_MEM;
      end
      ST_RD_MEM: begin
        cmd.rd_mem = 1'b1;
        state_nxt  = ST_RD_SEL;
      end
      ST_RD_SEL: begin
        cmd.sel_byte = 1'b1;
        valid_nxt    = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid  = valid_r;
  assign sweep_addr = cnt_r[AW-1:0];

  `LSP_ASSERT_NEXT(a_read_enters, clk, rst_n, accept && !quick && op_in == OP_READ, state_r == ST_RD_Q)
  `LSP_ASSERT_NEXT(a_read_strobe, clk, rst_n, state_r == ST_RD_SEL, valid_r && state_r == ST_IDLE)
  `LSP_ASSERT_NEXT(a_div_exit, clk, rst_n, div_last, state_r == ST_WRITE || state_r == ST_FILL)
  `LSP_ASSERT_NOW(a_quiet_clear, clk, rst_n, state_r == ST_CLEAR, !valid_r && busy)

endmodule

`default_nettype wire

// ===== design/led_strip_pixel_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                          Handshake
// command   start, busy, in_operation, in_position,        start && !busy
//           in_color, in_byte_index
// result    out_valid, out_data_byte, out_bad_index        one-cycle strobe
// config    cfg_we, cfg_index, cfg_wdata                   cfg_we
//
// Read byte: reciprocal multiply, store read, byte select, then the result strobe.
// Set pixel: the 8-step divider runs on the three channels, then the row is written.
// Fill all: the 8-step divider, then one store row written per cycle over LED_COUNT rows.
// Flagged words, pre-byte reads and the unused code: result strobes in the cycle after.
// After reset a clearing pass zeroes every store row; busy stays high until it ends.
// The receiver cannot stall; out_valid marks each result for one cycle.

module led_strip_pixel_encoder import lsp_pkg::*; #(
  parameter int LED_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [5:0]  in_position,
  input  wire logic [23:0] in_color,
  input  wire logic [9:0]  in_byte_index,
  output logic             out_valid,
  output logic [7:0]       out_data_byte,
  output logic             out_bad_index,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  // store address width; one row per LED
  localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  lsp_cmd_t    cmd;
  lsp_status_t status;
  logic [AW-1:0] sweep_addr;

  // controller: sequences clear, divide, write, fill and read steps
  lsp_ctrl #(
    .LED_COUNT (LED_COUNT),
    .AW        (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .status       (status),
    .busy         (busy),
    .out_valid    (out_valid),
    .cmd          (cmd),
    .sweep_addr   (sweep_addr)
  );

  // datapath: config registers, divider lanes, encoder, frame store
  lsp_datapath #(
    .LED_COUNT (LED_COUNT),
    .AW        (AW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_color      (in_color),
    .in_byte_index (in_byte_index),
    .cmd           (cmd),
    .sweep_addr    (sweep_addr),
    .status        (status),
    .out_data_byte (out_data_byte),
    .out_bad_index (out_bad_index)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lsp_pkg::*;

  localparam int LED_COUNT     = 64;
  localparam int STREAM_BYTES  = BYTES_PER_LED * LED_COUNT;
  // A fill walks every row, so this covers the slowest word and then some.
  localparam int SETTLE_CYCLES = LED_COUNT + 16;
  localparam int SEGMENT_WORDS = 285;

  // Line codes for one channel bit, sent MSB first.
  localparam logic [2:0] BIT_LOW  = 3'b100;
  localparam logic [2:0] BIT_HIGH = 3'b110;

  // Predicts the encoded frame store and queues the reply each word causes.
  class frame_scoreboard;
    typedef struct packed {
      logic [7:0] data_byte;
      logic       bad_index;
    } reply_t;

    logic [71:0] led_image [LED_COUNT];
    logic [7:0]  divisor;
    logic        swap_rg;
    reply_t      expected_replies [$];
    int          mismatches;
    int          reads, flagged, pixel_writes, fills, idle_codes, settings;

    function new();
      foreach (led_image[i]) led_image[i] = '0;
      divisor = '0;
      swap_rg = 1'b0;
    endfunction

    function void set_register(logic index, logic [7:0] value);
      settings++;
      if (index == CFG_DIVISOR) divisor = value;
      else swap_rg = value[0];
    endfunction

    function logic [7:0] dim(logic [7:0] level);
      if (divisor == 0) return '0;
      return level / divisor;
    endfunction

    function logic [23:0] line_code(logic [7:0] level);
      logic [23:0] code;
      code = '0;
      for (int b = 7; b >= 0; b--) code = {code[20:0], level[b] ? BIT_HIGH : BIT_LOW};
      return code;
    endfunction

    // G, R, B order; blue always from the low byte.
    function logic [71:0] encode_color(logic [23:0] color);
      logic [7:0] red, green;
      red   = swap_rg ? color[15:8] : color[23:16];
      green = swap_rg ? color[23:16] : color[15:8];
      return {line_code(dim(green)), line_code(dim(red)), line_code(dim(color[7:0]))};
    endfunction

    function void note_word(lsp_op_t op, logic [5:0] pos, logic [23:0] color,
                            logic [9:0] bidx);
      reply_t      reply;
      logic [71:0] image;
      int          k;
      reply = '0;
      case (op)
        OP_SET: begin
          pixel_writes++;
          if (int'(pos) < LED_COUNT) led_image[pos] = encode_color(color);
          else reply.bad_index = 1'b1;
        end
        OP_FILL: begin
          fills++;
          image = encode_color(color);
          foreach (led_image[i]) led_image[i] = image;
        end
        OP_READ: begin
          reads++;
          if (int'(bidx) > STREAM_BYTES) begin
            reply.bad_index = 1'b1;
            flagged++;
          end else if (bidx != 0) begin
            k = int'(bidx) - 1;
            reply.data_byte = led_image[k / BYTES_PER_LED][71 - 8*(k % BYTES_PER_LED) -: 8];
          end
        end
        default: idle_codes++;
      endcase
      expected_replies.push_back(reply);
    endfunction

    function void check_result(logic [7:0] data_byte, logic bad_index);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("result with no word outstanding: data_byte=%02h bad_index=%0b",
               data_byte, bad_index);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (data_byte !== want.data_byte) begin
        $error("data_byte mismatch: expected %02h, got %02h", want.data_byte, data_byte);
        mismatches++;
      end
      if (bad_index !== want.bad_index) begin
        $error("bad_index mismatch: expected %0b, got %0b", want.bad_index, bad_index);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [5:0]  in_position = '0;
  logic [23:0] in_color = '0;
  logic [9:0]  in_byte_index = '0;
  logic        out_valid;
  logic [7:0]  out_data_byte;
  logic        out_bad_index;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_DIVISOR;
  logic [7:0]  cfg_wdata = '0;

  frame_scoreboard frame_sb;
  int              idle_pct = 0;   // chance in 100 that the sender pauses after a word
  logic [5:0]      last_pos = '0;  // most recent pixel written, so reads hit live data

  led_strip_pixel_encoder #(.LED_COUNT(LED_COUNT)) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_color      (in_color),
    .in_byte_index (in_byte_index),
    .out_valid     (out_valid),
    .out_data_byte (out_data_byte),
    .out_bad_index (out_bad_index),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Results cannot be held off: take each strobe at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) frame_sb.check_result(out_data_byte, out_bad_index);
  end

  // Present one word from a falling edge and hold it until the block takes it.
  task automatic send_word(input lsp_op_t op, input logic [5:0] pos,
                           input logic [23:0] color, input logic [9:0] bidx);
    in_operation  = op;
    in_position   = pos;
    in_color      = color;
    in_byte_index = bidx;
    start         = 1'b1;
    do @(posedge clk); while (busy);
    frame_sb.note_word(op, pos, color, bidx);
    @(negedge clk);
    // Drop start for a random stretch so gaps land on every phase of the work.
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk);
    end
  endtask

  // Hold off until every reply is in and the block is idle again.
  task automatic settle();
    start = 1'b0;
    while (frame_sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_register(input logic index, input logic [7:0] value);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    frame_sb.set_register(index, value);
  endtask

  function automatic logic [23:0] pick_color();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 24'h000000;
    if (roll == 1) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  // Half the picks are bytes of the pixel just written; some pre-bytes, some past the end, the rest anywhere.
  function automatic logic [9:0] pick_read_index();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return '0;
    if (roll <= 2) return 10'($urandom_range(1023, STREAM_BYTES + 1));
    if (roll <= 12) return 10'(int'(last_pos) * BYTES_PER_LED + 1 + $urandom_range(8));
    return 10'($urandom_range(STREAM_BYTES, 1));
  endfunction

  task automatic random_words(input int count);
    int          roll;
    logic [5:0]  pos;
    logic [23:0] color;
    logic [9:0]  bidx;
    repeat (count) begin
      roll  = $urandom_range(99);
      pos   = 6'($urandom);
      color = pick_color();
      bidx  = 10'($urandom);
      if (roll < 55) begin
        send_word(OP_READ, pos, color, pick_read_index());
      end else if (roll < 85) begin
        last_pos = pos;
        send_word(OP_SET, pos, color, bidx);
      end else if (roll < 91) begin
        send_word(OP_FILL, pos, color, bidx);
      end else if (roll < 95) begin
        send_word(OP_NONE, pos, color, bidx);
      end else begin
        send_word(OP_READ, pos, color, 10'($urandom_range(1023, STREAM_BYTES + 1)));
      end
    end
  endtask

  initial begin
    frame_sb = new();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    // The block clears its store after reset; wait for that pass to finish.
    do @(negedge clk); while (busy);

    // Directed: fresh store reads as zero bytes, range edges, unused code.
    send_word(OP_READ, 6'd0, 24'h0, 10'd1);
    send_word(OP_READ, 6'd0, 24'h0, 10'(STREAM_BYTES));
    send_word(OP_READ, 6'd0, 24'h0, 10'(STREAM_BYTES + 1));
    send_word(OP_READ, 6'h3F, 24'hFFFFFF, 10'h3FF);
    send_word(OP_READ, 6'h3F, 24'hFFFFFF, 10'd0);
    send_word(OP_NONE, 6'h3F, 24'hFFFFFF, 10'h3FF);
    // Divisor still zero: a white pixel encodes as all-zero channels.
    send_word(OP_SET, 6'd5, 24'hFFFFFF, 10'd0);
    send_word(OP_READ, 6'd0, 24'h0, 10'd46);
    settle();
    write_register(CFG_DIVISOR, 8'd1);
    write_register(CFG_ORDER, 8'd1);
    send_word(OP_SET, 6'd0, 24'h123456, 10'd0);
    send_word(OP_READ, 6'd0, 24'h0, 10'd1);
    send_word(OP_READ, 6'd0, 24'h0, 10'd4);
    send_word(OP_READ, 6'd0, 24'h0, 10'd7);
    send_word(OP_READ, 6'd0, 24'h0, 10'd9);
    send_word(OP_SET, 6'h3F, 24'hFFFFFF, 10'd0);
    send_word(OP_READ, 6'd0, 24'h0, 10'(STREAM_BYTES - 8));
    send_word(OP_READ, 6'd0, 24'h0, 10'(STREAM_BYTES));
    send_word(OP_FILL, 6'd0, 24'hA5C30F, 10'd0);
    send_word(OP_READ, 6'd0, 24'h0, 10'd300);
    send_word(OP_READ, 6'd0, 24'h0, 10'd1);
    send_word(OP_SET, 6'h3F, 24'h000000, 10'd0);
    send_word(OP_READ, 6'd0, 24'h0, 10'(STREAM_BYTES));

    // Random segments, each under its own register setting; idle rates go by pairs of segments.
    for (int seg = 0; seg < 6; seg++) begin
      settle();
      case (seg)
        0: begin
          write_register(CFG_DIVISOR, 8'd1);
          write_register(CFG_ORDER, 8'd0);
        end
        1: begin
          write_register(CFG_DIVISOR, 8'd255);
          write_register(CFG_ORDER, 8'd1);
        end
        2: begin
          write_register(CFG_DIVISOR, 8'($urandom_range(254, 2)));
          write_register(CFG_ORDER, 8'd0);
        end
        3: begin
          write_register(CFG_DIVISOR, 8'd0);
          write_register(CFG_ORDER, 8'd1);
        end
        4: begin
          write_register(CFG_DIVISOR, 8'($urandom_range(255, 1)));
          write_register(CFG_ORDER, 8'($urandom_range(1)));
        end
        default: begin
          write_register(CFG_DIVISOR, 8'd1);
          write_register(CFG_ORDER, 8'd1);
        end
      endcase
      idle_pct = (seg < 2) ? 7 : (seg < 4) ? 52 : 0;
      random_words(SEGMENT_WORDS);
    end

    settle();
    $display("run covered %0d reads (%0d past the stream end), %0d pixel writes, %0d fills,",
             frame_sb.reads, frame_sb.flagged, frame_sb.pixel_writes, frame_sb.fills);
    $display("%0d unused-code words and %0d register writes across divisor and order extremes",
             frame_sb.idle_codes, frame_sb.settings);
    if (frame_sb.mismatches == 0 && frame_sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(10_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/lsp_pkg.sv
design/lsp_divider.sv
design/lsp_datapath.sv
design/lsp_ctrl.sv
design/led_strip_pixel_encoder.sv
test/testbench.sv
